// ===== hw/rtl/nmrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmrp_pkg
// Shared widths, codes and pipeline sideband type for the normal map
// renormalize and pack core.
// ----------------------------------------------------------------------------
package nmrp_pkg;

  localparam int FRAC_BITS = 12;
  localparam int MAG_W     = 8;                    // |2c - 255| fits in a byte
  localparam int SQR_W     = 2 * MAG_W;
  localparam int SUM_W     = SQR_W + 2;            // sum of three squares
  localparam int ROOT_W    = SUM_W / 2 + FRAC_BITS; // length with fraction bits

  // Square root: one result bit per pair of radicand bits.
  localparam int SQ_PAIRS     = ROOT_W;
  localparam int SQ_PER_STAGE = 3;
  localparam int SQ_STAGES    = SQ_PAIRS / SQ_PER_STAGE;
  localparam int SQ_REM_W     = ROOT_W + 3;

  // Packing: q = 255 * num / (2 * mq), num never exceeds 2 * mq.
  localparam int NUM_W         = ROOT_W + 1;
  localparam int PROD_W        = NUM_W + 8;
  localparam int QUO_W         = 8;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = QUO_W / DIV_PER_STAGE;

  // Input stage, sum stage, root stages, numerator stage, product stage,
  // divide stages.
  localparam int PIPE_DEPTH = 2 + SQ_STAGES + 2 + DIV_STAGES;
  localparam int SQRT_TAP   = 1 + SQ_STAGES;

  localparam logic MODE_NORMAL = 1'b0;
  localparam logic MODE_SWAP   = 1'b1;

  localparam logic CFG_MODE     = 1'b0;
  localparam logic CFG_CHANNELS = 1'b1;

  localparam logic [2:0] CH_ONE   = 3'd1;
  localparam logic [2:0] CH_THREE = 3'd3;
  localparam logic [2:0] CH_FOUR  = 3'd4;

  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_TWO  = 3'd2;

  typedef struct packed {
    logic             last;
    logic             err;
    logic             norm;
    logic [2:0]       nbytes;
    logic [7:0]       o0;
    logic [7:0]       o1;
    logic [7:0]       o2;
    logic [7:0]       o3;
    logic             neg_x;
    logic [MAG_W-1:0] mag_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_y;
  } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nmrp_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmrp_sqrt
// Pipelined restoring square root of sum * 2^(2*FRAC_BITS), truncated,
// a few result bits per stage.
// ----------------------------------------------------------------------------
module nmrp_sqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [nmrp_pkg::SUM_W-1:0]    sum,
  output logic      [nmrp_pkg::ROOT_W-1:0]   root
);
  import nmrp_pkg::*;

  logic [SUM_W-1:0]    rad_q  [SQ_STAGES-1];
  logic [SQ_REM_W-1:0] rem_q  [SQ_STAGES-1];
  logic [ROOT_W-1:0]   root_q [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [SUM_W-1:0]    rad_in;
    logic [SQ_REM_W-1:0] rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [SUM_W-1:0]    rad_v;
    logic [SQ_REM_W-1:0] rem_v;
    logic [ROOT_W-1:0]   root_v;
    logic [SQ_REM_W-1:0] trial;

    if (g == 0) begin : g_first
      assign rad_in  = sum;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    // The radicand is shifted out two bits per step; once the sum is used
    // up the fraction pairs come in as zeros.
    always_comb begin
      rad_v  = rad_in;
      rem_v  = rem_in;
      root_v = root_in;
      trial  = '0;
      for (int j = 0; j < SQ_PER_STAGE; j++) begin
        rem_v = {rem_v[SQ_REM_W-3:0], rad_v[SUM_W-1 -: 2]};
        rad_v = {rad_v[SUM_W-3:0], 2'b00};
        trial = {1'b0, root_v, 2'b01};
        if (rem_v >= trial) begin
          rem_v  = rem_v - trial;
          root_v = {root_v[ROOT_W-2:0], 1'b1};
        end else begin
          root_v = {root_v[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[g] <= root_v;
      end
    end

    if (g < SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[g] <= rad_v;
          rem_q[g] <= rem_v;
        end
      end
    end
  end

  assign root = root_q[SQ_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/nmrp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nmrp_div
// Two-lane pipelined restoring divider sharing one divisor, giving the
// eight-bit quotients of the x and y packing terms.
// ----------------------------------------------------------------------------
module nmrp_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [nmrp_pkg::PROD_W-1:0]   p_x,
  input  wire logic [nmrp_pkg::PROD_W-1:0]   p_y,
  input  wire logic [nmrp_pkg::NUM_W-1:0]    den,
  output logic      [nmrp_pkg::QUO_W-1:0]    q_x,
  output logic      [nmrp_pkg::QUO_W-1:0]    q_y
);
  import nmrp_pkg::*;

  logic [PROD_W-1:0] rx_q [DIV_STAGES-1];
  logic [PROD_W-1:0] ry_q [DIV_STAGES-1];
  logic [PROD_W-1:0] d_q  [DIV_STAGES-1];
  logic [QUO_W-1:0]  qx_q [DIV_STAGES];
  logic [QUO_W-1:0]  qy_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [PROD_W-1:0] rx_in;
    logic [PROD_W-1:0] ry_in;
    logic [PROD_W-1:0] d_in;
    logic [QUO_W-1:0]  qx_in;
    logic [QUO_W-1:0]  qy_in;
    logic [PROD_W-1:0] rx_v;
    logic [PROD_W-1:0] ry_v;
    logic [PROD_W-1:0] d_v;
    logic [QUO_W-1:0]  qx_v;
    logic [QUO_W-1:0]  qy_v;

    if (g == 0) begin : g_first
      assign rx_in = p_x;
      assign ry_in = p_y;
      assign d_in  = PROD_W'({den, {(QUO_W-1){1'b0}}});
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign rx_in = rx_q[g-1];
      assign ry_in = ry_q[g-1];
      assign d_in  = d_q[g-1];
      assign qx_in = qx_q[g-1];
      assign qy_in = qy_q[g-1];
    end

    // The divisor starts aligned to the top quotient bit and walks down.
    always_comb begin
      rx_v = rx_in;
      ry_v = ry_in;
      d_v  = d_in;
      qx_v = qx_in;
      qy_v = qy_in;
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        if (rx_v >= d_v) begin
          rx_v = rx_v - d_v;
          qx_v = {qx_v[QUO_W-2:0], 1'b1};
        end else begin
          qx_v = {qx_v[QUO_W-2:0], 1'b0};
        end
        if (ry_v >= d_v) begin
          ry_v = ry_v - d_v;
          qy_v = {qy_v[QUO_W-2:0], 1'b1};
        end else begin
          qy_v = {qy_v[QUO_W-2:0], 1'b0};
        end
        d_v = {1'b0, d_v[PROD_W-1:1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qx_q[g] <= qx_v;
        qy_q[g] <= qy_v;
      end
    end

    if (g < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rx_q[g] <= rx_v;
          ry_q[g] <= ry_v;
          d_q[g]  <= d_v;
        end
      end
    end
  end

  assign q_x = qx_q[DIV_STAGES-1];
  assign q_y = qy_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/normal_map_renormalize_pack_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normal_map_renormalize_pack_core
// Per-pixel normal renormalization to two bytes, red/blue swap, or copy.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless the output stalls; the 7-stage
// square root and 4-stage divider set the depth. An output stall freezes
// the whole pipeline. Reset clears all valid bits and sets mode to swap,
// channel count to 3.
// ----------------------------------------------------------------------------
module normal_map_renormalize_pack_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // byte0, byte1, byte2, byte3
  input  wire logic        s_tlast,   // last_pixel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // out0, out1, out2, out3, out_bytes, zero pad
  output logic      [0:0]  m_tuser,   // pixel_error
  output logic             m_tlast,   // last_out
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [2:0]  cfg_data
);
  import nmrp_pkg::*;

  logic       mode;
  logic [2:0] channel_count;
  logic       en;

  logic [7:0] byte0, byte1, byte2, byte3;
  logic       err;
  side_t      side_in;
  logic [MAG_W-1:0] mag_z;

  logic [PIPE_DEPTH-1:0] vld_q;
  side_t                 side_q [PIPE_DEPTH];
  logic [SQR_W-1:0]      sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]      sum_q;
  logic [ROOT_W-1:0]     root;
  logic [ROOT_W-1:0]     mq;
  logic [NUM_W-1:0]      mq_ext, ax_sh, ay_sh, num_x, num_y;
  logic [NUM_W-1:0]      num_x_q, num_y_q, den_q, den2_q;
  logic [PROD_W-1:0]     px_q, py_q;
  logic [QUO_W-1:0]      q_x, q_y;

  logic [7:0] o0, o1, o2, o3;
  logic [2:0] nbytes;
  logic       pix_err;
  logic       last_out;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SWAP;
      channel_count <= CH_THREE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode          <= cfg_data[0];
        CFG_CHANNELS: channel_count <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ----------------------------------------------------------------- input
  assign byte0 = s_tdata[7:0];
  assign byte1 = s_tdata[15:8];
  assign byte2 = s_tdata[23:16];
  assign byte3 = s_tdata[31:24];

  assign err = !(channel_count == CH_ONE || channel_count == CH_THREE ||
                 channel_count == CH_FOUR) ||
               (mode == MODE_NORMAL && channel_count == CH_ONE);

  // |2c - 255| is {c[6:0], 1} for the upper half and its complement below.
  assign mag_z = byte2[7] ? {byte2[6:0], 1'b1} : {~byte2[6:0], 1'b1};

  always_comb begin
    side_in        = '0;
    side_in.last   = s_tlast;
    side_in.err    = err;
    side_in.neg_x  = !byte0[7];
    side_in.mag_x  = byte0[7] ? {byte0[6:0], 1'b1} : {~byte0[6:0], 1'b1};
    side_in.neg_y  = !byte1[7];
    side_in.mag_y  = byte1[7] ? {byte1[6:0], 1'b1} : {~byte1[6:0], 1'b1};
    if (err) begin
      side_in.nbytes = BYTES_NONE;
    end else if (mode == MODE_NORMAL) begin
      side_in.norm   = 1'b1;
      side_in.nbytes = BYTES_TWO;
    end else if (channel_count == CH_ONE) begin
      side_in.o0     = byte0;
      side_in.nbytes = BYTES_ONE;
    end else begin
      side_in.o0     = byte2;
      side_in.o1     = byte1;
      side_in.o2     = byte0;
      side_in.o3     = (channel_count == CH_FOUR) ? byte3 : 8'd0;
      side_in.nbytes = channel_count;
    end
  end

  // ------------------------------------------------- valid and sideband line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ------------------------------------------------------ squares and sum
  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= side_in.mag_x * side_in.mag_x;
      sq_y  <= side_in.mag_y * side_in.mag_y;
      sq_z  <= mag_z * mag_z;
      sum_q <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    end
  end

  nmrp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .sum  (sum_q),
    .root (root)
  );

  // ------------------------------------------- numerators and the product
  assign mq     = (root == '0) ? ROOT_W'(1) : root;
  assign mq_ext = NUM_W'(mq);
  assign ax_sh  = NUM_W'({side_q[SQRT_TAP].mag_x, {FRAC_BITS{1'b0}}});
  assign ay_sh  = NUM_W'({side_q[SQRT_TAP].mag_y, {FRAC_BITS{1'b0}}});

  // A negative numerator clamps to zero.
  always_comb begin
    if (!side_q[SQRT_TAP].neg_x) begin
      num_x = mq_ext + ax_sh;
    end else if (ax_sh > mq_ext) begin
      num_x = '0;
    end else begin
      num_x = mq_ext - ax_sh;
    end
    if (!side_q[SQRT_TAP].neg_y) begin
      num_y = mq_ext + ay_sh;
    end else if (ay_sh > mq_ext) begin
      num_y = '0;
    end else begin
      num_y = mq_ext - ay_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x_q <= num_x;
      num_y_q <= num_y;
      den_q   <= {mq, 1'b0};
      px_q    <= PROD_W'({num_x_q, 8'd0}) - PROD_W'(num_x_q);
      py_q    <= PROD_W'({num_y_q, 8'd0}) - PROD_W'(num_y_q);
      den2_q  <= den_q;
    end
  end

  nmrp_div u_div (
    .clk (clk),
    .en  (en),
    .p_x (px_q),
    .p_y (py_q),
    .den (den2_q),
    .q_x (q_x),
    .q_y (q_y)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o0       <= side_q[PIPE_DEPTH-1].norm ? q_x : side_q[PIPE_DEPTH-1].o0;
      o1       <= side_q[PIPE_DEPTH-1].norm ? q_y : side_q[PIPE_DEPTH-1].o1;
      o2       <= side_q[PIPE_DEPTH-1].o2;
      o3       <= side_q[PIPE_DEPTH-1].o3;
      nbytes   <= side_q[PIPE_DEPTH-1].nbytes;
      pix_err  <= side_q[PIPE_DEPTH-1].err;
      last_out <= side_q[PIPE_DEPTH-1].last;
    end
  end

  assign m_tdata = {5'd0, nbytes, o3, o2, o1, o0};
  assign m_tuser = pix_err;
  assign m_tlast = last_out;

endmodule
`default_nettype wire

// ===== tb/pixel_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_result_checker
// Watches the pixel input, result output and register write port of the
// normal map renormalize and pack core. It predicts every result from its own
// copy of the registers and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module pixel_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  input  wire logic [0:0]  m_tuser,
  input  wire logic        m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  output int unsigned      mismatches,
  output int unsigned      outstanding,
  output int unsigned      checked
);
  import nmrp_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] o0;
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
    logic [2:0] nbytes;
    logic [4:0] pad;
    logic       err;
    logic       last;
  } pix_result_t;

  pix_result_t pending_pixels[$];
  pix_result_t want;
  pix_result_t got;
  logic        cur_mode;
  logic [2:0]  cur_channels;

  // Largest r with r * r <= x, built one bit at a time from the top.
  function automatic longint floor_root(input longint x);
    longint r;
    longint trial;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // Maps one signed component onto 0..255 against the fixed-point length.
  function automatic logic [7:0] scale_axis(input longint v, input longint len_q);
    longint num;
    longint q;
    num = len_q + v * (longint'(1) << FRAC_BITS);
    if (num < 0) num = 0;
    q = (255 * num) / (2 * len_q);
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic pix_result_t predict_pixel(input logic m, input logic [2:0] cc,
                                                input logic [31:0] data, input logic last);
    pix_result_t r;
    longint      vx;
    longint      vy;
    longint      vz;
    longint      len_q;
    r = '0;
    r.last = last;
    if (!(cc == CH_ONE || cc == CH_THREE || cc == CH_FOUR) ||
        (m == MODE_NORMAL && cc == CH_ONE)) begin
      r.err = 1'b1;
      return r;
    end
    if (m == MODE_NORMAL) begin
      vx = 2 * longint'(data[7:0]) - 255;
      vy = 2 * longint'(data[15:8]) - 255;
      vz = 2 * longint'(data[23:16]) - 255;
      len_q = floor_root((vx * vx + vy * vy + vz * vz) << (2 * FRAC_BITS));
      if (len_q == 0) len_q = 1;
      r.o0 = scale_axis(vx, len_q);
      r.o1 = scale_axis(vy, len_q);
      r.nbytes = BYTES_TWO;
    end else if (cc == CH_ONE) begin
      r.o0 = data[7:0];
      r.nbytes = BYTES_ONE;
    end else begin
      r.o0 = data[23:16];
      r.o1 = data[15:8];
      r.o2 = data[7:0];
      r.o3 = (cc == CH_FOUR) ? data[31:24] : 8'd0;
      r.nbytes = cc;
    end
    return r;
  endfunction

  task automatic report(input string what, input int want_v, input int got_v);
    if (mismatches < MAX_REPORTS)
      $display("mismatch on result %0d: %s expected %0d, got %0d",
               checked, what, want_v, got_v);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) report(what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_mode <= MODE_SWAP;
      cur_channels <= CH_THREE;
      pending_pixels.delete();
      mismatches = 0;
      checked = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MODE) cur_mode <= cfg_data[0];
        else cur_channels <= cfg_data;
      end
      if (s_tvalid && s_tready)
        pending_pixels.push_back(predict_pixel(cur_mode, cur_channels, s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        got.o0 = m_tdata[7:0];
        got.o1 = m_tdata[15:8];
        got.o2 = m_tdata[23:16];
        got.o3 = m_tdata[31:24];
        got.nbytes = m_tdata[34:32];
        got.pad = m_tdata[39:35];
        got.err = m_tuser[0];
        got.last = m_tlast;
        if (pending_pixels.size() == 0) begin
          report("result with no pixel outstanding, out_bytes", 0, got.nbytes);
        end else begin
          want = pending_pixels.pop_front();
          check_field("out0", want.o0, got.o0);
          check_field("out1", want.o1, got.o1);
          check_field("out2", want.o2, got.o2);
          check_field("out3", want.o3, got.o3);
          check_field("out_bytes", want.nbytes, got.nbytes);
          check_field("tdata padding", want.pad, got.pad);
          check_field("pixel_error", want.err, got.err);
          check_field("last_out", want.last, got.last);
        end
        checked++;
      end
      outstanding <= pending_pixels.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the normal map renormalize and pack core: a directed pass over
// the field extremes and every mode and channel count, then random pixel
// streams under several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import nmrp_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [2:0]  cfg_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned cycles;
  int unsigned sent_pixels;
  int unsigned settings_used;
  int unsigned hold_requests;

  normal_map_renormalize_pack_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycles, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: short random stalls, calm stretches, and a long hold-off
  // on each request so the pipeline fills and pushes back on the input.
  initial begin
    int stall_left;
    bit calm;
    int unsigned holds_done;
    m_tready = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 299) == 0) calm = !calm;
        if (!calm && $urandom_range(0, 4) == 0)
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
      end
    end
  end

  function automatic int next_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Component byte for normal mode: mostly uniform, with a share of nearly
  // zero components and of saturated ones.
  function automatic logic [7:0] axis_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 8'($urandom_range(0, 255));
    if (pick < 8) return 8'($urandom_range(120, 135));
    return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [2:0] bad_count(input int idx);
    case (idx)
      0: return 3'd0;
      1: return 3'd2;
      2: return 3'd5;
      3: return 3'd6;
      default: return 3'd7;
    endcase
  endfunction

  task automatic send_pixel(input logic [31:0] data, input logic last, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sent_pixels++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic set_config(input logic m, input logic [2:0] cc);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data <= {junk, m};
    @(posedge clk);
    cfg_index <= CFG_CHANNELS;
    cfg_data <= cc;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic m, input logic [2:0] cc, input int count,
                           input bit hold);
    bit          quiet;
    logic [31:0] data;
    set_config(m, cc);
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (hold && i == count / 4) hold_requests++;
      if (m == MODE_NORMAL)
        data = {8'($urandom_range(0, 255)), axis_byte(), axis_byte(), axis_byte()};
      else
        data = $urandom;
      send_pixel(data, $urandom_range(0, 7) == 0, next_gap(quiet));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    sent_pixels = 0;
    settings_used = 1;
    hold_requests = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: swap with three channels.
    send_pixel(32'h78563412, 1'b0, 0);

    set_config(MODE_NORMAL, CH_THREE);
    send_pixel(32'h00000000, 1'b0, 0);
    send_pixel(32'h00FFFFFF, 1'b0, 0);
    send_pixel(32'h0080807F, 1'b0, 0);   // shortest possible vector
    send_pixel(32'h007F7F80, 1'b0, 1);
    send_pixel(32'h0080FF00, 1'b0, 0);
    send_pixel(32'h007F00FF, 1'b0, 0);
    send_pixel(32'h55641EC8, 1'b1, 2);

    set_config(MODE_NORMAL, CH_FOUR);     // alpha is dropped
    send_pixel(32'hFF4DF00A, 1'b0, 0);
    send_pixel(32'h000000FF, 1'b1, 0);

    set_config(MODE_NORMAL, CH_ONE);      // unsupported in normal mode
    send_pixel(32'h12345678, 1'b1, 0);

    set_config(MODE_SWAP, CH_ONE);
    send_pixel(32'hFFFFFFA5, 1'b1, 0);

    set_config(MODE_SWAP, CH_FOUR);
    send_pixel(32'h7FFE8001, 1'b0, 0);
    send_pixel(32'hFF000000, 1'b1, 0);

    set_config(MODE_SWAP, CH_THREE);      // alpha ignored
    send_pixel(32'hC3A55A3C, 1'b0, 0);

    for (int k = 0; k < 5; k++) begin
      set_config(MODE_SWAP, bad_count(k));
      send_pixel(32'hFFFFFFFF, k[0], 0);
    end
    set_config(MODE_NORMAL, bad_count(0));
    send_pixel(32'h01020304, 1'b1, 0);
    set_config(MODE_NORMAL, bad_count(4));
    send_pixel(32'hFEFDFCFB, 1'b0, 0);

    run_phase(MODE_NORMAL, CH_THREE, 300, 1'b0);
    run_phase(MODE_NORMAL, CH_FOUR, 200, 1'b1);
    run_phase(MODE_SWAP, CH_FOUR, 150, 1'b0);
    run_phase(MODE_SWAP, CH_THREE, 150, 1'b0);
    run_phase(MODE_SWAP, CH_ONE, 100, 1'b0);
    run_phase(MODE_NORMAL, CH_ONE, 40, 1'b0);
    run_phase(MODE_SWAP, bad_count($urandom_range(0, 4)), 40, 1'b0);
    run_phase(MODE_NORMAL, bad_count($urandom_range(0, 4)), 40, 1'b0);
    run_phase(MODE_NORMAL, CH_THREE, 130, 1'b1);

    drain();
    $display("Sent %0d pixels under %0d register settings and checked %0d results.",
             sent_pixels, settings_used, checked);
    $display("Covered both modes, channel counts 0 to 7, random stalls and long hold-offs.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
